/* src/vrt_pkg.sv */
package vrt_pkg;

  // result word kinds
  typedef enum logic [1:0] {
    KIND_QUERY = 2'd0,
    KIND_HIT   = 2'd1,
    KIND_MISS  = 2'd2
  } kind_e;

  // input opcodes
  localparam logic OP_START  = 1'b0;
  localparam logic OP_ANSWER = 1'b1;

  // per-axis step codes
  localparam logic [1:0] STEP_NONE = 2'b00;
  localparam logic [1:0] STEP_POS  = 2'b01;
  localparam logic [1:0] STEP_NEG  = 2'b11;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_ROOT_GO,
    ST_ROOT,
    ST_AX,
    ST_DIV1,
    ST_DIV2,
    ST_STEP,
    ST_OUT
  } state_e;

endpackage

/* src/vrt_sqrt.sv */
module vrt_sqrt
  import vrt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] v_q, r_q, bit_q;
  logic        run_q, done_q;
  logic [63:0] trial;

  assign trial  = r_q + bit_q;
  assign done_o = done_q;
  assign root_o = r_q[31:0];

  // one result bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
      end else if (run_q && bit_q == 64'd1) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      r_q   <= '0;
      bit_q <= 64'd1 << 62;
    end else if (run_q) begin
      if (v_q >= trial) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

/* src/vrt_div.sv */
module vrt_div
  import vrt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic [31:0] rem_q, lo_q, den_q;
  logic [4:0]  cnt_q;
  logic        run_q, done_q;
  logic [32:0] trial;
  logic        qbit;

  assign trial  = {rem_q, lo_q[31]};
  assign qbit   = trial >= {1'b0, den_q};
  assign done_o = done_q;
  assign quot_o = lo_q;

  // control: saturation finishes at once, else 32 restoring steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (num_i[63:32] >= den_i) begin
          done_q <= 1'b1;
        end else begin
          run_q <= 1'b1;
        end
      end else if (run_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient shifts into the low word
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= num_i[63:32];
      lo_q  <= (num_i[63:32] >= den_i) ? SAT32 : num_i[31:0];
    end else if (run_q) begin
      rem_q <= qbit ? 32'(trial - {1'b0, den_q}) : trial[31:0];
      lo_q  <= {lo_q[30:0], qbit};
    end
  end

endmodule

/* src/voxel_ray_traversal_top.sv */
// Voxel ray walk in Q16.16. An opcode-0 word starts a ray and, after setup,
// yields a query word for the origin voxel (or a miss at once for a zero
// direction or a zero limit). Each opcode-1 word answers the pending query
// and yields a hit, the next query, or a miss; answers while no ray is
// active give nothing. An answer goes through the step and output states
// before its result is registered. On a start the direction length comes
// from a one-bit-per-cycle square root, and each nonzero direction axis
// needs two 32-step divisions on one shared restoring divider; squares and
// the boundary product share one 32x32 multiplier. Input is stalled while a
// word is being worked on; the output register holds one finished word.
module voxel_ray_traversal_top
  import vrt_pkg::*;
#(
  parameter int INT_BITS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  input  logic [30:0]        max_distance_i,
  input  logic               solid_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic signed [15:0] voxel_x_o,
  output logic signed [15:0] voxel_y_o,
  output logic signed [15:0] voxel_z_o,
  output logic signed [15:0] prev_x_o,
  output logic signed [15:0] prev_y_o,
  output logic signed [15:0] prev_z_o,
  output logic [31:0]        distance_o
);

  state_e state_q, state_d;

  logic [1:0]           ax_q;
  logic [FRAC_BITS-1:0] frac_q [3];
  logic [31:0]          mag_q  [3];
  logic                 neg_q  [3];
  logic [INT_BITS-1:0]  cur_q  [3];
  logic [INT_BITS-1:0]  last_q [3];
  logic [1:0]           step_q [3];
  logic [31:0]          nb_q   [3];
  logic [31:0]          span_q [3];
  logic [63:0]          sum_q, prod_q;
  logic [31:0]          len_q, trav_q, lim_q;
  logic                 busy_q, solid_q;
  kind_e                pend_q;

  logic        out_valid_q;
  kind_e       out_kind_q;
  logic [15:0] out_vox_q [3];
  logic [15:0] out_prev_q [3];
  logic [31:0] out_dist_q;

  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  logic [31:0]        mag_in [3];

  logic        in_acc, out_free;
  logic [FRAC_BITS:0] bnd;
  logic [31:0] mul_a, mul_b;
  logic        div_start, div_done, root_done;
  logic [63:0] div_num;
  logic [31:0] div_quot, root;
  logic [1:0]  sel;
  logic [32:0] nb_sum;

  assign org = '{origin_x_i, origin_y_i, origin_z_i};
  assign dir = '{dir_x_i, dir_y_i, dir_z_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = dir[i][31] ? 32'(-dir[i]) : dir[i];
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // distance to the first boundary along the current axis
  assign bnd = neg_q[ax_q] ? {1'b0, frac_q[ax_q]}
                           : ((FRAC_BITS+1)'(1) << FRAC_BITS) - {1'b0, frac_q[ax_q]};

  // shared multiplier operands
  assign mul_a = (state_q == ST_MUL) ? mag_q[ax_q] : 32'(bnd);
  assign mul_b = (state_q == ST_MUL) ? mag_q[ax_q] : len_q;

  assign div_start = (state_q == ST_AX && mag_q[ax_q] != 32'd0) ||
                     (state_q == ST_DIV1 && div_done);
  assign div_num   = (state_q == ST_AX) ? (64'(len_q) << FRAC_BITS) : prod_q;

  // step axis: smallest boundary, ties to z then y
  always_comb begin
    if (nb_q[0] < nb_q[1] && nb_q[0] < nb_q[2]) begin
      sel = 2'd0;
    end else if (nb_q[1] < nb_q[2]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
  end
  assign nb_sum = {1'b0, nb_q[sel]} + {1'b0, span_q[sel]};

  vrt_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_ROOT_GO),
    .value_i (sum_q),
    .done_o  (root_done),
    .root_o  (root)
  );

  vrt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (mag_q[ax_q]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (opcode_i == OP_START) begin
            if ((mag_in[0] | mag_in[1] | mag_in[2]) == 32'd0 || max_distance_i == 31'd0) begin
              state_d = ST_OUT;
            end else begin
              state_d = ST_MUL;
            end
          end else if (busy_q) begin
            state_d = ST_STEP;
          end
        end
      end
      ST_MUL:     state_d = ST_ACC;
      ST_ACC:     state_d = (ax_q == 2'd2) ? ST_ROOT_GO : ST_MUL;
      ST_ROOT_GO: state_d = ST_ROOT;
      ST_ROOT:    if (root_done) state_d = ST_AX;
      ST_AX: begin
        if (mag_q[ax_q] != 32'd0) begin
          state_d = ST_DIV1;
        end else if (ax_q == 2'd2) begin
          state_d = ST_OUT;
        end
      end
      ST_DIV1:    if (div_done) state_d = ST_DIV2;
      ST_DIV2: begin
        if (div_done) state_d = (ax_q == 2'd2) ? ST_OUT : ST_AX;
      end
      ST_STEP:    state_d = ST_OUT;
      ST_OUT:     if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ray state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ax_q   <= '0;
      trav_q <= '0;
      lim_q  <= '0;
      pend_q <= KIND_MISS;
      for (int i = 0; i < 3; i++) begin
        cur_q[i]  <= '0;
        last_q[i] <= '0;
        step_q[i] <= STEP_NONE;
        nb_q[i]   <= '0;
        span_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && opcode_i == OP_START) begin
            busy_q <= 1'b0;
            trav_q <= '0;
            lim_q  <= {1'b0, max_distance_i};
            ax_q   <= '0;
            pend_q <= KIND_MISS;
            for (int i = 0; i < 3; i++) begin
              cur_q[i]  <= INT_BITS'(org[i] >>> FRAC_BITS);
              last_q[i] <= INT_BITS'(org[i] >>> FRAC_BITS);
            end
          end
        end
        ST_ACC: begin
          ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
        end
        ST_AX: begin
          if (mag_q[ax_q] == 32'd0) begin
            step_q[ax_q] <= STEP_NONE;
            nb_q[ax_q]   <= SAT32;
            span_q[ax_q] <= SAT32;
            if (ax_q == 2'd2) begin
              busy_q <= 1'b1;
              pend_q <= KIND_QUERY;
            end else begin
              ax_q <= ax_q + 2'd1;
            end
          end else begin
            step_q[ax_q] <= neg_q[ax_q] ? STEP_NEG : STEP_POS;
          end
        end
        ST_DIV1: begin
          if (div_done) span_q[ax_q] <= div_quot;
        end
        ST_DIV2: begin
          if (div_done) begin
            nb_q[ax_q] <= div_quot;
            if (ax_q == 2'd2) begin
              busy_q <= 1'b1;
              pend_q <= KIND_QUERY;
            end else begin
              ax_q <= ax_q + 2'd1;
            end
          end
        end
        ST_STEP: begin
          if (solid_q) begin
            busy_q <= 1'b0;
            pend_q <= KIND_HIT;
          end else begin
            for (int i = 0; i < 3; i++) begin
              last_q[i] <= cur_q[i];
            end
            trav_q <= nb_q[sel];
            case (step_q[sel])
              STEP_POS: cur_q[sel] <= cur_q[sel] + INT_BITS'(1);
              STEP_NEG: cur_q[sel] <= cur_q[sel] - INT_BITS'(1);
              default:  cur_q[sel] <= cur_q[sel];
            endcase
            nb_q[sel] <= nb_sum[32] ? SAT32 : nb_sum[31:0];
            if (nb_q[sel] < lim_q) begin
              pend_q <= KIND_QUERY;
            end else begin
              busy_q <= 1'b0;
              pend_q <= KIND_MISS;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // setup datapath; also latches the solid flag of each accepted word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      solid_q <= solid_i;
      if (opcode_i == OP_START) begin
        for (int i = 0; i < 3; i++) begin
          frac_q[i] <= org[i][FRAC_BITS-1:0];
          mag_q[i]  <= mag_in[i];
          neg_q[i]  <= dir[i][31];
        end
        sum_q <= '0;
      end
    end
    if (state_q == ST_MUL || state_q == ST_AX) begin
      prod_q <= mul_a * mul_b;
    end
    if (state_q == ST_ACC) begin
      sum_q <= sum_q + prod_q;
    end
    if (state_q == ST_ROOT && root_done) begin
      len_q <= root;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      out_kind_q <= pend_q;
      out_dist_q <= (pend_q == KIND_HIT) ? trav_q : 32'd0;
      for (int i = 0; i < 3; i++) begin
        out_vox_q[i]  <= (pend_q == KIND_MISS) ? 16'd0 : 16'(cur_q[i]);
        out_prev_q[i] <= (pend_q == KIND_HIT) ? 16'(last_q[i]) : 16'd0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign voxel_x_o   = out_vox_q[0];
  assign voxel_y_o   = out_vox_q[1];
  assign voxel_z_o   = out_vox_q[2];
  assign prev_x_o    = out_prev_q[0];
  assign prev_y_o    = out_prev_q[1];
  assign prev_z_o    = out_prev_q[2];
  assign distance_o  = out_dist_q;

endmodule

/* src/vrt_checker.sv */
module vrt_checker
  import vrt_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         kind_o,
  input logic signed [15:0] voxel_x_o,
  input logic signed [15:0] prev_x_o,
  input logic [31:0]        distance_o
);

  // kind code is always a defined one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == KIND_QUERY || kind_o == KIND_HIT || kind_o == KIND_MISS))
    else $error("undefined result kind");

  // a miss carries no voxel and no distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_MISS |-> voxel_x_o == 16'd0 && distance_o == 32'd0)
    else $error("miss word carries data");

  // a query carries no previous voxel and no distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_QUERY |-> prev_x_o == 16'd0 && distance_o == 32'd0)
    else $error("query word carries hit data");

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(distance_o))
    else $error("stalled result changed");

endmodule

bind voxel_ray_traversal_top vrt_checker u_vrt_checker (.*);
